// File: rtl/cibw_pkg.sv
// Shared types and constants for the compressed integer bit writer.
// No dependencies; every other file but cibw_out_if and cibw_checker imports this package.
package cibw_pkg;

	localparam int MAX_BYTES   = 8;
	localparam int VALUE_W     = 8 * MAX_BYTES;
	localparam int CNT_W       = 4;
	localparam int IDX_W       = $clog2(MAX_BYTES);
	// One token holds at most one prefix byte of flags plus all value bytes.
	localparam int TOK_W       = VALUE_W + 8;
	localparam int LEN_W       = $clog2(TOK_W + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] MATCH_SIGNED = 8'hFF;
	localparam logic [7:0] MATCH_UNSIGNED = 8'h00;
	localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

	typedef enum logic {
		KIND_ENCODE = 1'b0,
		KIND_FLUSH  = 1'b1
	} kind_t;

	// Bit string for one request, left-aligned, plus its length.
	typedef struct packed {
		logic             flush;
		logic [TOK_W-1:0] bits;
		logic [LEN_W-1:0] len;
	} token_t;

endpackage

// File: rtl/cibw_in_if.sv
// Input channel of the compressed integer bit writer: valid/ready plus item fields.
// Depends on cibw_pkg for field widths.
interface cibw_in_if;
	import cibw_pkg::*;

	logic                valid;
	logic                ready;
	logic                kind;
	logic [VALUE_W-1:0]  value;
	logic [CNT_W-1:0]    byte_count;
	logic                unsigned_data;

	modport source (output valid, kind, value, byte_count, unsigned_data, input ready);
	modport sink   (input valid, kind, value, byte_count, unsigned_data, output ready);

endinterface

// File: rtl/cibw_out_if.sv
// Output channel of the compressed integer bit writer: valid/ready plus stream byte.
// No dependencies.
interface cibw_out_if;

	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [3:0] bits_valid;
	logic       last_of_run;

	modport source (output valid, out_byte, bits_valid, last_of_run, input ready);
	modport sink   (input valid, out_byte, bits_valid, last_of_run, output ready);

endinterface

// File: rtl/cibw_front.sv
// Front end: registers each request and turns it into a left-aligned bit token.
// Depends on cibw_pkg and cibw_in_if.
module cibw_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_order,
	cibw_in_if.sink         in_ch,
	output logic            tok_valid,
	input  logic            tok_ready,
	output cibw_pkg::token_t tok
);
	import cibw_pkg::*;

	logic               valid_s1;
	logic               kind_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [CNT_W-1:0]   count_s1;
	logic               uns_s1;

	logic [CNT_W-1:0]   cnt;
	logic [IDX_W-1:0]   top;
	logic [7:0]         match;
	logic               mism;
	logic [IDX_W-1:0]   idx;
	logic [IDX_W-1:0]   ones;
	logic [7:0]         prefix;
	logic [7:0]         b0;
	logic               short_tail;
	logic [8:0]         tail;
	logic [VALUE_W-1:0] rev;
	logic [VALUE_W-1:0] payload;
	logic [IDX_W:0]     nbytes;

	assign in_ch.ready = !valid_s1 || tok_ready;
	assign tok_valid   = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_s1  <= in_ch.kind;
			value_s1 <= in_ch.value;
			count_s1 <= in_ch.byte_count;
			uns_s1   <= in_ch.unsigned_data;
		end
	end

	always_comb begin
		// clamp the byte count into 1..MAX_BYTES
		if (count_s1 == '0) begin
			cnt = CNT_W'(1);
		end else if (count_s1 > CNT_W'(MAX_BYTES)) begin
			cnt = CNT_W'(MAX_BYTES);
		end else begin
			cnt = count_s1;
		end
		top   = IDX_W'(cnt - CNT_W'(1));
		match = uns_s1 ? MATCH_UNSIGNED : MATCH_SIGNED;

		// highest byte above byte 0 that differs from the match byte
		mism = 1'b0;
		idx  = '0;
		for (int k = 1; k < MAX_BYTES; k++) begin
			if ((IDX_W'(k) <= top) && (value_s1[8*k +: 8] != match)) begin
				mism = 1'b1;
				idx  = IDX_W'(k);
			end
		end

		ones   = mism ? (top - idx) : top;
		prefix = ~(8'hFF >> ones);

		b0         = value_s1[7:0];
		short_tail = (b0 & HIGH_NIBBLE) == (match & HIGH_NIBBLE);
		tail       = short_tail ? {1'b1, b0[3:0], 4'b0000} : {1'b0, b0};

		for (int k = 0; k < MAX_BYTES; k++) begin
			rev[VALUE_W-8-8*k +: 8] = value_s1[8*k +: 8];
		end
		nbytes = {1'b0, idx} + (IDX_W+1)'(1);
		if (byte_order) begin
			// highest remaining byte first: drop the bytes above it off the top
			payload = value_s1 << {(IDX_W'(MAX_BYTES - 1) - idx), 3'b000};
		end else begin
			// byte 0 first: keep only the leading remaining bytes
			payload = rev & ~({VALUE_W{1'b1}} >> {nbytes, 3'b000});
		end

		tok.flush = (kind_s1 == KIND_FLUSH);
		if (kind_s1 == KIND_FLUSH) begin
			tok.bits = '0;
			tok.len  = '0;
		end else if (mism) begin
			tok.bits = {prefix, {VALUE_W{1'b0}}}
				| ({8'h00, payload} << (IDX_W'(MAX_BYTES - 1) - ones));
			tok.len  = LEN_W'(ones) + LEN_W'(1) + LEN_W'({nbytes, 3'b000});
		end else begin
			tok.bits = {prefix, {VALUE_W{1'b0}}} | ({tail, {(TOK_W-9){1'b0}}} >> ones);
			tok.len  = LEN_W'(ones) + (short_tail ? LEN_W'(5) : LEN_W'(9));
		end
	end

endmodule

// File: rtl/cibw_queue.sv
// Short token queue between the front and back ends.
// Depends on cibw_pkg for the token type and depth.
module cibw_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  cibw_pkg::token_t push_tok,
	output logic             pop_valid,
	input  logic             pop_ready,
	output cibw_pkg::token_t pop_tok
);
	import cibw_pkg::*;

	token_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_tok    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

// File: rtl/cibw_back.sv
// Back end: merges tokens behind the pending bits and emits one stream byte a cycle while out_ch is free.
// Depends on cibw_pkg and cibw_out_if.
module cibw_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	output logic             tok_ready,
	input  cibw_pkg::token_t tok,
	cibw_out_if.source       out_ch
);
	import cibw_pkg::*;

	logic [TOK_W-1:0] acc_q;
	logic [LEN_W-1:0] cnt_q;
	logic             flush_q;
	logic             ovalid_q;
	logic [7:0]       obyte_q;
	logic [3:0]       obits_q;
	logic             olast_q;

	logic             load;
	logic [TOK_W-1:0] w_acc;
	logic [LEN_W-1:0] w_cnt;
	logic             w_flush;
	logic             out_free;
	logic             emit_full;
	logic             emit;

	// take a new token only once fewer than a byte of bits is left and no flush is pending
	assign tok_ready = (cnt_q < LEN_W'(8)) && !flush_q;
	assign load      = tok_valid && tok_ready;
	assign out_free  = !ovalid_q || out_ch.ready;

	assign out_ch.valid       = ovalid_q;
	assign out_ch.out_byte    = obyte_q;
	assign out_ch.bits_valid  = obits_q;
	assign out_ch.last_of_run = olast_q;

	always_comb begin
		w_acc   = acc_q;
		w_cnt   = cnt_q;
		w_flush = flush_q;
		if (load) begin
			if (tok.flush) begin
				w_flush = cnt_q != '0;
			end else begin
				w_acc = acc_q | (tok.bits >> cnt_q[2:0]);
				w_cnt = cnt_q + tok.len;
			end
		end
		emit_full = w_cnt >= LEN_W'(8);
		emit      = out_free && (emit_full || w_flush);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			flush_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
				flush_q  <= 1'b0;
				if (emit_full) begin
					acc_q <= w_acc << 8;
					cnt_q <= w_cnt - LEN_W'(8);
				end else begin
					acc_q <= '0;
					cnt_q <= '0;
				end
			end else begin
				if (out_ch.ready) begin
					ovalid_q <= 1'b0;
				end
				acc_q   <= w_acc;
				cnt_q   <= w_cnt;
				flush_q <= w_flush;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q <= w_acc[TOK_W-1 -: 8];
			obits_q <= emit_full ? 4'd8 : w_cnt[3:0];
			// last byte of the request when what stays behind is under a byte
			olast_q <= emit_full ? (w_cnt < LEN_W'(16)) : 1'b1;
		end
	end

endmodule

// File: rtl/compressed_integer_bit_writer.sv
// Top level of the compressed integer bit writer: byte-order register, front, queue, back.
// Depends on cibw_pkg, cibw_in_if, cibw_out_if, cibw_front, cibw_queue, cibw_back.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    kind, value[63:0], byte_count[3:0], unsigned_data
//   out_ch    out  valid/ready    out_byte[7:0], bits_valid[3:0], last_of_run
//   cfg       in   cfg_we         cfg_wdata = byte_order
//
// The front takes one request a cycle while the queue has room; the back emits one stream
// byte a cycle while out_ch is ready, and takes a new token only once fewer than a byte
// of bits is pending and no flush waits. The first byte passes the front's request register,
// a queue entry and the output register. Reset clears the pending bits, the queue and byte_order.
// Either channel may stall freely; the two-entry queue and output register keep the sides apart.
module compressed_integer_bit_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	cibw_in_if.sink     in_ch,
	cibw_out_if.source  out_ch
);
	import cibw_pkg::*;

	logic   byte_order_q;
	logic   f_valid;
	logic   f_ready;
	token_t f_tok;
	logic   b_valid;
	logic   b_ready;
	token_t b_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= 1'b0;
		end else if (cfg_we) begin
			byte_order_q <= cfg_wdata;
		end
	end

	cibw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_order (byte_order_q),
		.in_ch      (in_ch),
		.tok_valid  (f_valid),
		.tok_ready  (f_ready),
		.tok        (f_tok)
	);

	cibw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_tok   (f_tok),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_tok    (b_tok)
	);

	cibw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (b_valid),
		.tok_ready (b_ready),
		.tok       (b_tok),
		.out_ch    (out_ch)
	);

endmodule

// File: rtl/cibw_checker.sv
// Port-level checks for the compressed integer bit writer, bound to the top level.
// Depends on compressed_integer_bit_writer.
module cibw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [3:0] bits_valid,
	input logic       last_of_run
);

	// hold a stalled byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(bits_valid) && $stable(last_of_run))
		else $error("stalled output byte changed");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bits_valid >= 4'd1 && bits_valid <= 4'd8)
		else $error("bits_valid out of range");

	// a partial byte only comes from a flush, which ends its request
	a_partial_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bits_valid != 4'd8 |-> last_of_run)
		else $error("partial byte not marked last");

	a_partial_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bits_valid < 4'd8 |-> (out_byte & (8'hFF >> bits_valid)) == 8'h00)
		else $error("flush padding not zero");

endmodule

bind compressed_integer_bit_writer cibw_checker u_cibw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_byte    (out_ch.out_byte),
	.bits_valid  (out_ch.bits_valid),
	.last_of_run (out_ch.last_of_run)
);

// File: dv/tb_compressed_integer_bit_writer.sv
// Testbench for compressed_integer_bit_writer: random and directed encode/flush requests,
// expected stream bytes from a bit-level scoreboard, random stalls on both channels.
// Depends on cibw_pkg, cibw_in_if, cibw_out_if and the RTL top level.
module tb_compressed_integer_bit_writer;
	timeunit 1ns;
	timeprecision 1ps;
	import cibw_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] bits_valid;
		logic       last_of_run;
	} stream_byte_t;

	// Bit packer: tracks the partial byte and queues every stream byte it completes.
	class cibw_stream_model;
		logic [7:0]   acc_bits;
		int           acc_count;
		logic         byte_order;
		stream_byte_t expected_bytes[$];
		int           mismatch_count;

		function new();
			acc_bits = '0;
			acc_count = 0;
			byte_order = 1'b0;
			mismatch_count = 0;
		endfunction

		task report(string msg);
			$display("%t: mismatch: %s", $time, msg);
			mismatch_count++;
		endtask

		function void queue_byte(logic [7:0] b, logic [3:0] bv, logic last);
			stream_byte_t sb;
			sb.out_byte = b;
			sb.bits_valid = bv;
			sb.last_of_run = last;
			expected_bytes.insert(expected_bytes.size(), sb);
		endfunction

		function void shift_in_bit(logic b);
			acc_bits = {acc_bits[6:0], b};
			acc_count++;
			if (acc_count == 8) begin
				queue_byte(acc_bits, 4'd8, 1'b0);
				acc_bits = '0;
				acc_count = 0;
			end
		endfunction

		function void shift_in_bits(logic [7:0] v, int n);
			for (int j = n - 1; j >= 0; j--)
				shift_in_bit(v[j]);
		endfunction

		function void encode_value(logic [VALUE_W-1:0] value, int n, logic uns);
			logic [7:0] match;
			logic [7:0] b;
			match = uns ? MATCH_UNSIGNED : MATCH_SIGNED;
			for (int i = n - 1; i >= 1; i--) begin
				b = value[8*i +: 8];
				shift_in_bit(b == match);
				if (b != match) begin
					// emit the remaining bytes, highest first or byte 0 first as byte_order selects
					if (byte_order) begin
						for (int k = i; k >= 0; k--)
							shift_in_bits(value[8*k +: 8], 8);
					end else begin
						for (int k = 0; k <= i; k++)
							shift_in_bits(value[8*k +: 8], 8);
					end
					return;
				end
			end
			b = value[7:0];
			if ((b & HIGH_NIBBLE) == (match & HIGH_NIBBLE)) begin
				shift_in_bit(1'b1);
				shift_in_bits({4'h0, b[3:0]}, 4);
			end else begin
				shift_in_bit(1'b0);
				shift_in_bits(b, 8);
			end
		endfunction

		function void note_request(logic kind, logic [VALUE_W-1:0] value,
				logic [CNT_W-1:0] cnt, logic uns);
			int           n;
			int           prior_size;
			logic [7:0]   aligned;
			prior_size = expected_bytes.size();
			if (kind == KIND_FLUSH) begin
				if (acc_count > 0) begin
					aligned = acc_bits << (8 - acc_count);
					queue_byte(aligned, 4'(acc_count), 1'b1);
					acc_bits = '0;
					acc_count = 0;
				end
			end else begin
				n = (cnt == 0) ? 1 : (cnt > MAX_BYTES) ? MAX_BYTES : int'(cnt);
				encode_value(value, n, uns);
				if (expected_bytes.size() > prior_size)
					expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
			end
		endfunction

		task check_byte(logic [7:0] b, logic [3:0] bv, logic last);
			stream_byte_t want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected stream byte %02h", b));
				return;
			end
			want = expected_bytes.pop_front();
			if (b !== want.out_byte)
				report($sformatf("out_byte %02h, want %02h", b, want.out_byte));
			if (bv !== want.bits_valid)
				report($sformatf("bits_valid %0d, want %0d", bv, want.bits_valid));
			if (last !== want.last_of_run)
				report($sformatf("last_of_run %0b, want %0b", last, want.last_of_run));
		endtask

		task check_leftover();
			if (expected_bytes.size() != 0)
				report($sformatf("%0d stream bytes never arrived", expected_bytes.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   quiet_cycles = 0;

	cibw_stream_model stream_model;

	cibw_in_if  in_ch();
	cibw_out_if out_ch();

	compressed_integer_bit_writer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				stream_model.byte_order = cfg_wdata;
			if (in_ch.valid && in_ch.ready)
				stream_model.note_request(in_ch.kind, in_ch.value, in_ch.byte_count,
					in_ch.unsigned_data);
			if (out_ch.valid && out_ch.ready)
				stream_model.check_byte(out_ch.out_byte, out_ch.bits_valid,
					out_ch.last_of_run);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task send_request(logic kind, logic [VALUE_W-1:0] value, logic [CNT_W-1:0] cnt,
			logic uns);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.value <= value;
		in_ch.byte_count <= cnt;
		in_ch.unsigned_data <= uns;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Hold off new requests until every expected byte is out, then let the pipe settle.
	task wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (stream_model.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_byte_order(logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Leading bytes equal to the match byte, then a break; upper unused bytes stay random.
	function automatic logic [VALUE_W-1:0] shaped_value(int n, logic uns);
		logic [VALUE_W-1:0] v;
		logic [7:0]         match;
		int                 brk;
		v = {$urandom, $urandom};
		match = uns ? MATCH_UNSIGNED : MATCH_SIGNED;
		if ($urandom_range(9) == 0)
			return v;
		brk = $urandom_range(n - 1);
		for (int k = brk + 1; k < n; k++)
			v[8*k +: 8] = match;
		if (brk == 0) begin
			case ($urandom_range(2))
				0: v[7:4] = match[7:4];
				1: v[7:0] = match;
				default: ;
			endcase
		end else if ($urandom_range(3) == 0) begin
			v[8*brk +: 8] = match ^ (8'h01 << $urandom_range(7));
		end
		return v;
	endfunction

	task run_directed();
		send_request(KIND_ENCODE, 64'h0, 4'd1, 1'b1);
		send_request(KIND_FLUSH, 64'h0, 4'd1, 1'b0);
		send_request(KIND_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
		send_request(KIND_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
		send_request(KIND_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
		send_request(KIND_ENCODE, 64'h0, 4'd8, 1'b1);
		send_request(KIND_ENCODE, 64'h80, 4'd1, 1'b0);
		send_request(KIND_ENCODE, 64'h0F, 4'd1, 1'b1);
		send_request(KIND_ENCODE, 64'h10, 4'd1, 1'b1);
		send_request(KIND_ENCODE, 64'hF5, 4'd1, 1'b0);
		// zero count acts as one byte, oversize counts clamp to eight
		send_request(KIND_ENCODE, 64'hFFFF_FFFF_FFFF_FF12, 4'd0, 1'b1);
		send_request(KIND_ENCODE, 64'h0000_00AB_CDEF_0000, 4'd9, 1'b1);
		send_request(KIND_ENCODE, 64'h8000_0000_0000_0001, 4'd15, 1'b0);
		send_request(KIND_ENCODE, 64'hDEAD_BEEF_0000_0005, 4'd4, 1'b1);
		send_request(KIND_ENCODE, 64'h5555_5555_5555_5555, 4'd8, 1'b1);
		send_request(KIND_ENCODE, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 1'b0);
		send_request(KIND_ENCODE, 64'h0000_0000_0000_FF7F, 4'd2, 1'b0);
		send_request(KIND_FLUSH, 64'h0, 4'd1, 1'b0);
	endtask

	task run_random(int count, int pause_at);
		logic [CNT_W-1:0] cnt;
		int               n;
		logic             uns;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_drained();
			uns = $urandom_range(1);
			if ($urandom_range(9) == 0) begin
				send_request(KIND_FLUSH, {$urandom, $urandom}, 4'($urandom), uns);
			end else begin
				if ($urandom_range(19) == 0)
					cnt = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
				else
					cnt = 4'($urandom_range(8, 1));
				n = (cnt == 0) ? 1 : (cnt > MAX_BYTES) ? MAX_BYTES : int'(cnt);
				send_request(KIND_ENCODE, shaped_value(n, uns), cnt, uns);
			end
		end
	endtask

	initial begin
		stream_model = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_ENCODE;
		in_ch.value = '0;
		in_ch.byte_count = 4'd1;
		in_ch.unsigned_data = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 32;
		recv_idle_pct = 63;
		write_byte_order(1'b0);
		run_directed();
		wait_drained();

		write_byte_order(1'b1);
		run_random(150, 75);
		wait_drained();

		send_idle_pct = 63;
		recv_idle_pct = 32;
		write_byte_order(1'b0);
		run_random(150, -1);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_byte_order(1'b1);
		run_random(150, -1);
		wait_drained();

		stream_model.check_leftover();
		if (stream_model.mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/cibw_pkg.sv
rtl/cibw_in_if.sv
rtl/cibw_out_if.sv
rtl/cibw_front.sv
rtl/cibw_queue.sv
rtl/cibw_back.sv
rtl/compressed_integer_bit_writer.sv
rtl/cibw_checker.sv
dv/tb_compressed_integer_bit_writer.sv
